/* hdl/open_addressing_hash_table_assert.svh */
// Assertion macros for the hash table block
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define OAHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OAHT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OAHT_ASSERT(label, clk, rst, prop, msg)
`define OAHT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hdl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // slot count; a power of two so the home slot and the probe wrap are bit slices
   localparam int CAPACITY = 1024;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [6:0]  LOAD_RESET = 7'd70;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   localparam logic [1:0] ST_EMPTY    = 2'd0;
   localparam logic [1:0] ST_OCCUPIED = 2'd1;
   localparam logic [1:0] ST_TOMB     = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
   localparam logic [1:0] STATUS_LOAD    = 2'd2;

   // byte address of the max_load_percent register
   localparam logic [1:0] ADDR_MAX_LOAD = 2'd0;

   // job handed from the hashing front end to the probing back end
   typedef struct packed {
      logic        cmd;
      logic [63:0] key;
      logic [63:0] value;
      logic [31:0] hash;
   } job_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_HASH,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_CLEAR,
      BE_IDLE,
      BE_READ,
      BE_CHECK,
      BE_COMMIT,
      BE_OUT
   } be_state_type;

endpackage

/* hdl/oaht_if.sv */
// ----------------------------------------------------------------------------
// oaht_req_if / oaht_rsp_if
// Valid/ready channels of the hash table.
// ----------------------------------------------------------------------------
interface oaht_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] key;
   logic [63:0] value;
   modport source (output valid, cmd, key, value, input ready);
   modport sink (input valid, cmd, key, value, output ready);
endinterface

interface oaht_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] read_value;
   logic [1:0]  status;
   logic [10:0] live_count;
   modport source (output valid, found, read_value, status, live_count, input ready);
   modport sink (input valid, found, read_value, status, live_count, output ready);
endinterface

/* hdl/oaht_front.sv */
// ----------------------------------------------------------------------------
// oaht_front
// Accepts requests, normalizes the key and hashes it one byte per cycle.
// ----------------------------------------------------------------------------
module oaht_front #(
   parameter int KEY_BYTES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   oaht_req_if.sink             req,
   output logic                 job_valid,
   input  logic                 job_ready,
   output oaht_pkg::job_type    job
);
   localparam int CW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   oaht_pkg::fe_state_type state_ff, state_in;
   oaht_pkg::job_type      job_ff, job_in;
   logic [CW-1:0]          byte_ff, byte_in;
   logic [63:0]            raw_ff, raw_in;
   logic [7:0]             cur_byte;
   logic [31:0]            mixed;

   assign cur_byte = raw_ff[8*byte_ff +: 8];
   assign mixed = (job_ff.hash ^ {24'd0, cur_byte}) * oaht_pkg::FNV_PRIME;

   // state, job and key byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oaht_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      byte_ff <= byte_in;
      raw_ff  <= raw_in;
   end

   // take a request, one byte step per cycle until a zero byte or KEY_BYTES, then offer the job
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      byte_in   = byte_ff;
      raw_in    = raw_ff;
      req.ready = 1'b0;
      job_valid = 1'b0;
      job       = job_ff;
      unique case (state_ff)
         oaht_pkg::FE_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               job_in.cmd   = req.cmd;
               job_in.value = req.value;
               job_in.key   = 64'd0;
               job_in.hash  = oaht_pkg::FNV_BASIS;
               raw_in       = req.key;
               byte_in      = '0;
               state_in     = oaht_pkg::FE_HASH;
            end
         end
         oaht_pkg::FE_HASH: begin
            if (cur_byte == 8'd0) begin
               state_in = oaht_pkg::FE_PUSH;
            end else begin
               job_in.hash = mixed;
               job_in.key[8*byte_ff +: 8] = cur_byte;
               if (32'(byte_ff) == KEY_BYTES - 1) begin
                  state_in = oaht_pkg::FE_PUSH;
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end
         end
         oaht_pkg::FE_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) begin
               state_in = oaht_pkg::FE_IDLE;
            end
         end
         default: state_in = oaht_pkg::FE_IDLE;
      endcase
   end
endmodule

/* hdl/oaht_queue.sv */
// ----------------------------------------------------------------------------
// oaht_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module oaht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  oaht_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output oaht_pkg::job_type out_job
);
   oaht_pkg::job_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ff] <= in_job;
   end
endmodule

/* hdl/oaht_back.sv */
// ----------------------------------------------------------------------------
// oaht_back
// Probes the slot memory, applies gets, sets and deletes, issues results.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_assert.svh"
module oaht_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  oaht_pkg::job_type job,
   input  logic [6:0]        max_load,
   oaht_rsp_if.source        rsp
);
   localparam int CAPACITY = oaht_pkg::CAPACITY;
   localparam int AW = $clog2(CAPACITY);
   localparam int NW = AW + 1;
   localparam int LW = NW + 7;

   // slot memories
   logic [1:0]  st_mem [CAPACITY];
   logic [63:0] key_mem [CAPACITY];
   logic [63:0] val_mem [CAPACITY];
   logic [1:0]  st_rd_ff;
   logic [63:0] key_rd_ff, val_rd_ff;

   oaht_pkg::be_state_type state_ff, state_in;
   oaht_pkg::job_type      job_ff, job_in;
   logic [AW-1:0] idx_ff, idx_in, tomb_ff, tomb_in, slot_ff, slot_in;
   logic [NW-1:0] probe_ff, probe_in;
   logic          have_tomb_ff, have_tomb_in, hit_ff, hit_in;
   logic [NW-1:0] live_ff, live_in, tombs_ff, tombs_in;
   logic          found_ff, found_in;
   logic [63:0]   rv_ff, rv_in;
   logic [1:0]    status_ff, status_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [1:0]    wr_st;
   logic [63:0]   wr_key, wr_val;
   logic          wr_kv;
   logic [LW-1:0] need, limit;
   logic          get_commit;

   assign need  = LW'((NW+1)'(live_ff) + (NW+1)'(tombs_ff) + 1'b1) * LW'(100);
   assign limit = LW'(CAPACITY) * LW'(max_load);

   // memory ports: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_mem[wr_addr] <= wr_st;
         if (wr_kv) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
         end
      end
      st_rd_ff  <= st_mem[idx_ff];
      key_rd_ff <= key_mem[idx_ff];
      val_rd_ff <= val_mem[idx_ff];
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oaht_pkg::BE_CLEAR;
         idx_ff   <= '0;
         live_ff  <= '0;
         tombs_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         live_ff  <= live_in;
         tombs_ff <= tombs_in;
      end
      job_ff       <= job_in;
      tomb_ff      <= tomb_in;
      slot_ff      <= slot_in;
      probe_ff     <= probe_in;
      have_tomb_ff <= have_tomb_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      rv_ff        <= rv_in;
      status_ff    <= status_in;
   end

   assign rsp.found      = found_ff;
   assign rsp.read_value = rv_ff;
   assign rsp.status     = status_ff;
   assign rsp.live_count = 11'(live_ff);

   // probe sequencer: clear the slots after reset; per job read a slot, check it, move on, then commit and respond
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      tomb_in      = tomb_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      have_tomb_in = have_tomb_ff;
      hit_in       = hit_ff;
      live_in      = live_ff;
      tombs_in     = tombs_ff;
      found_in     = found_ff;
      rv_in        = rv_ff;
      status_in    = status_ff;
      job_ready    = 1'b0;
      rsp.valid    = 1'b0;
      wr_en   = 1'b0;
      wr_kv   = 1'b0;
      wr_addr = slot_ff;
      wr_st   = oaht_pkg::ST_EMPTY;
      wr_key  = job_ff.key;
      wr_val  = job_ff.value;
      unique case (state_ff)
         oaht_pkg::BE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == AW'(CAPACITY - 1)) state_in = oaht_pkg::BE_IDLE;
         end
         oaht_pkg::BE_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in       = job;
               idx_in       = job.hash[AW-1:0];
               probe_in     = '0;
               have_tomb_in = 1'b0;
               state_in     = oaht_pkg::BE_READ;
            end
         end
         oaht_pkg::BE_READ: begin
            state_in = oaht_pkg::BE_CHECK;
         end
         oaht_pkg::BE_CHECK: begin
            priority if (st_rd_ff == oaht_pkg::ST_OCCUPIED && key_rd_ff == job_ff.key) begin
               hit_in = 1'b1; slot_in = idx_ff; probe_in = '0;
               state_in = oaht_pkg::BE_COMMIT;
            end else if (st_rd_ff == oaht_pkg::ST_EMPTY) begin
               hit_in = 1'b0;
               slot_in = have_tomb_ff ? tomb_ff : idx_ff;
               probe_in = '0;
               state_in = oaht_pkg::BE_COMMIT;
            end else begin
               if (st_rd_ff == oaht_pkg::ST_TOMB && !have_tomb_ff) begin
                  have_tomb_in = 1'b1; tomb_in = idx_ff;
               end
               idx_in = idx_ff + 1'b1;
               if (probe_ff == NW'(CAPACITY - 1)) begin
                  hit_in = 1'b0;
                  slot_in = tomb_in;
                  // probe_in all-ones flags no usable slot when no tombstone
                  probe_in = (have_tomb_in) ? '0 : '1;
                  state_in = oaht_pkg::BE_COMMIT;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  state_in = oaht_pkg::BE_READ;
               end
            end
         end
         oaht_pkg::BE_COMMIT: begin
            found_in  = 1'b0;
            rv_in     = 64'd0;
            status_in = oaht_pkg::STATUS_OK;
            wr_addr   = slot_ff;
            if (job_ff.cmd == oaht_pkg::CMD_GET) begin
               if (hit_ff) begin
                  found_in = 1'b1;
                  rv_in    = val_rd_ff;
               end
            end else if (probe_ff == '1) begin
               status_in = oaht_pkg::STATUS_NO_SLOT;
            end else if (hit_ff) begin
               found_in = 1'b1;
               wr_en = 1'b1; wr_kv = 1'b1;
               if (job_ff.value == 64'd0) begin
                  wr_st  = oaht_pkg::ST_TOMB;
                  wr_key = 64'd0;
                  if (live_ff != '0) live_in = live_ff - 1'b1;
                  tombs_in = tombs_ff + 1'b1;
               end else begin
                  wr_st = oaht_pkg::ST_OCCUPIED;
               end
            end else if (job_ff.value != 64'd0) begin
               if (need < limit) begin
                  wr_en = 1'b1; wr_kv = 1'b1;
                  wr_st = oaht_pkg::ST_OCCUPIED;
                  // the chosen slot is a tombstone only if one was recorded
                  if (have_tomb_ff && tombs_ff != '0) tombs_in = tombs_ff - 1'b1;
                  live_in = live_ff + 1'b1;
               end else begin
                  status_in = oaht_pkg::STATUS_LOAD;
               end
            end
            state_in = oaht_pkg::BE_OUT;
         end
         oaht_pkg::BE_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = oaht_pkg::BE_IDLE;
         end
         default: state_in = oaht_pkg::BE_IDLE;
      endcase
   end

   assign get_commit = (state_ff == oaht_pkg::BE_COMMIT) && (job_ff.cmd == oaht_pkg::CMD_GET);

   `OAHT_ASSERT(a_live_bound, clock, reset, live_ff + tombs_ff <= NW'(CAPACITY), "count overflow")
   `OAHT_ASSERT(a_status_code, clock, reset, rsp.valid |-> rsp.status != 2'd3, "bad status")
   `OAHT_ASSERT(a_get_nowrite, clock, reset, get_commit |-> !wr_en, "get wrote memory")
endmodule

/* hdl/open_addressing_hash_table.sv */
// Flow: the front end hashes the key byte by byte (stopping early for short keys),
// the job passes the queue, then the back end reads and checks each probed slot,
// commits and responds. The front end can take a new request while the back end
// is still probing for an earlier one.
// Reset: synchronous; a clearing pass over all CAPACITY slots empties the slot
// states before the first request leaves the queue; max_load_percent resets to 70.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Key/value table with FNV-1a hashing and linear probing with tombstones.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
   parameter int KEY_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   oaht_req_if.sink    req,
   oaht_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0]        max_load_ff;
   logic              fe_valid, fe_ready, be_valid, be_ready;
   oaht_pkg::job_type fe_job, be_job;

   // configuration register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_load_ff <= oaht_pkg::LOAD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == oaht_pkg::ADDR_MAX_LOAD) begin
         max_load_ff <= csr_pwdata[6:0];
      end
   end
   assign csr_prdata = (csr_paddr == oaht_pkg::ADDR_MAX_LOAD) ? {25'd0, max_load_ff} : 32'd0;

   oaht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req,
      .job_valid(fe_valid), .job_ready(fe_ready), .job(fe_job)
   );

   oaht_queue u_queue (
      .clock, .reset,
      .in_valid(fe_valid), .in_ready(fe_ready), .in_job(fe_job),
      .out_valid(be_valid), .out_ready(be_ready), .out_job(be_job)
   );

   oaht_back u_back (
      .clock, .reset,
      .job_valid(be_valid), .job_ready(be_ready), .job(be_job),
      .max_load(max_load_ff), .rsp
   );
endmodule

/* bench/open_addressing_hash_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash table result checker
// Watches the request and response channels, keeps a shadow copy of the
// table (FNV-1a hash, linear probing with tombstones, load limit) and checks
// each response transfer against the predicted result, all fields compared together.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_checker #(
   parameter int CAPACITY  = 1024,
   parameter int KEY_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   oaht_req_if        req,
   oaht_rsp_if        rsp,
   input  logic [6:0] load_percent,
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct packed {
      logic        found;
      logic [63:0] read_value;
      logic [1:0]  status;
      logic [10:0] live_count;
   } answer_type;

   logic [1:0]  shadow_state [CAPACITY];
   logic [63:0] shadow_key   [CAPACITY];
   logic [63:0] shadow_value [CAPACITY];
   int unsigned live_total;
   int unsigned tomb_total;
   answer_type  answer_queue [$];

   // normalize key bytes and hash them
   function automatic logic [31:0] fnv_hash(input logic [63:0] key,
                                            output logic [63:0] norm);
      logic [31:0] h;
      logic [7:0]  b;
      h    = oaht_pkg::FNV_BASIS;
      norm = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         b = key[8*i +: 8];
         if (b == 8'd0) break;
         norm[8*i +: 8] = b;
         h = (h ^ {24'd0, b}) * oaht_pkg::FNV_PRIME;
      end
      return h;
   endfunction

   // apply one operation to the shadow table, return expected response
   function automatic answer_type table_apply(input logic cmd, input logic [63:0] key,
                                              input logic [63:0] value);
      answer_type  a;
      logic [63:0] norm;
      logic [31:0] h;
      int unsigned start, idx, slot, tomb;
      bit          have_tomb, hit, ok;
      h = fnv_hash(key, norm);
      start = h % CAPACITY;
      have_tomb = 0; hit = 0; ok = 0; slot = 0; tomb = 0;
      for (int p = 0; p < CAPACITY; p++) begin
         idx = (start + p) % CAPACITY;
         if (shadow_state[idx] == oaht_pkg::ST_OCCUPIED && shadow_key[idx] == norm) begin
            slot = idx; hit = 1; ok = 1; break;
         end
         if (shadow_state[idx] == oaht_pkg::ST_TOMB && !have_tomb) begin
            tomb = idx; have_tomb = 1;
         end else if (shadow_state[idx] == oaht_pkg::ST_EMPTY) begin
            slot = have_tomb ? tomb : idx; ok = 1; break;
         end
      end
      if (!ok && have_tomb) begin
         slot = tomb; ok = 1;
      end
      a = '0;
      if (cmd == oaht_pkg::CMD_GET) begin
         if (ok && hit) begin
            a.found = 1'b1;
            a.read_value = shadow_value[slot];
         end
      end else if (!ok) begin
         a.status = oaht_pkg::STATUS_NO_SLOT;
      end else if (hit) begin
         a.found = 1'b1;
         if (value == 64'd0) begin
            shadow_state[slot] = oaht_pkg::ST_TOMB;
            if (live_total > 0) live_total--;
            tomb_total++;
         end else begin
            shadow_value[slot] = value;
         end
      end else if (value != 64'd0) begin
         if ((live_total + tomb_total + 1) * 100 < CAPACITY * load_percent) begin
            if (shadow_state[slot] == oaht_pkg::ST_TOMB && tomb_total > 0) tomb_total--;
            shadow_state[slot] = oaht_pkg::ST_OCCUPIED;
            shadow_key[slot]   = norm;
            shadow_value[slot] = value;
            live_total++;
         end else begin
            a.status = oaht_pkg::STATUS_LOAD;
         end
      end
      a.live_count = live_total[10:0];
      return a;
   endfunction

   assign pending_count = answer_queue.size();

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) shadow_state[i] <= oaht_pkg::ST_EMPTY;
         live_total     <= 0;
         tomb_total     <= 0;
         mismatch_count <= 0;
         answer_queue.delete();
      end else begin
         if (req.valid && req.ready)
            answer_queue.push_back(table_apply(req.cmd, req.key, req.value));
         if (rsp.valid && rsp.ready) begin
            got = {rsp.found, rsp.read_value, rsp.status, rsp.live_count};
            if (answer_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response transfer with nothing expected: %p", $realtime, got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

/* bench/open_addressing_hash_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash table testbench
// Drives get/set/delete traffic in bursts with a stalling receiver, changes
// the load limit between phases over APB and lets the checker judge results.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;

   localparam int CAPACITY = oaht_pkg::CAPACITY;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic [6:0]  load_percent = oaht_pkg::LOAD_RESET;
   int          mismatch_count, pending_count;
   logic [63:0] key_pool [16];

   oaht_req_if req ();
   oaht_rsp_if rsp ();

   open_addressing_hash_table #(.KEY_BYTES(8)) i_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   open_addressing_hash_table_checker #(.CAPACITY(CAPACITY), .KEY_BYTES(8)) i_checker (
      .clock, .reset, .req, .rsp, .load_percent, .mismatch_count, .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern: stretches of always-ready and of random stalls
   always @(posedge clock) begin
      int unsigned phase;
      phase = 32'(($time / 20000) % 3);
      if (reset) rsp.ready <= 1'b0;
      else if (phase == 0) rsp.ready <= 1'b1;
      else if (phase == 1) rsp.ready <= ($urandom_range(3) != 0);
      else rsp.ready <= ($urandom_range(3) == 0);
   end

   // one request transfer; valid stays high after it when hold is set, for back-to-back items
   task automatic send_item(input logic cmd, input logic [63:0] key,
                            input logic [63:0] value, input bit hold);
      req.valid <= 1'b1;
      req.cmd   <= cmd;
      req.key   <= key;
      req.value <= value;
      do @(posedge clock); while (!req.ready);
      if (!hold) req.valid <= 1'b0;
   endtask

   task automatic send_burst(input logic cmd, input logic [63:0] key, input logic [63:0] value);
      send_item(cmd, key, value, $urandom_range(3) != 0);
      if ($urandom_range(4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_load(input logic [6:0] pct);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= oaht_pkg::ADDR_MAX_LOAD; csr_pwdata <= {25'd0, pct};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      load_percent = pct;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // key with a random length and random junk after the terminator
   function automatic logic [63:0] random_key();
      logic [63:0] k;
      int unsigned n;
      k = random_word();
      n = $urandom_range(8);
      if (n < 8) k[8*n +: 8] = 8'd0;
      return k;
   endfunction

   // gets, deletes and sets mixed over pooled and fresh keys
   task automatic random_phase(input int count, input int unsigned pool_bias);
      logic [63:0] k, v;
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(99) < pool_bias) ? key_pool[$urandom_range(15)] : random_key();
         r = $urandom_range(9);
         v = (r < 6) ? 64'd0 : random_word();
         send_burst((r < 4) ? oaht_pkg::CMD_GET : oaht_pkg::CMD_SET, k, v);
      end
      wait_idle();
   endtask

   initial begin
      req.valid = 1'b0; req.cmd = oaht_pkg::CMD_GET; req.key = '0; req.value = '0;
      for (int i = 0; i < 16; i++) key_pool[i] = random_key();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty key, junk after terminator, full-width keys, extremes
      send_item(oaht_pkg::CMD_GET, 64'd0, 64'd0, 0);
      send_item(oaht_pkg::CMD_SET, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_item(oaht_pkg::CMD_GET, 64'hFFFF_FFFF_FFFF_FF00, 64'd0, 0);
      send_item(oaht_pkg::CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1);
      send_item(oaht_pkg::CMD_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1);
      send_item(oaht_pkg::CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF, 0);
      send_item(oaht_pkg::CMD_SET, 64'h0000_0000_0041_0041, 64'h1234, 0);
      send_item(oaht_pkg::CMD_GET, 64'h0000_0000_0000_0041, 64'd0, 0);
      send_item(oaht_pkg::CMD_SET, 64'h41, 64'd0, 0);
      send_item(oaht_pkg::CMD_SET, 64'h41, 64'd0, 0);
      send_item(oaht_pkg::CMD_GET, 64'h41, 64'd0, 0);
      send_item(oaht_pkg::CMD_SET, 64'h41, 64'h5555_AAAA_5555_AAAA, 0);
      send_item(oaht_pkg::CMD_SET, 64'h0101_0101_0101_0101, 64'hAAAA_5555_AAAA_5555, 0);
      send_item(oaht_pkg::CMD_GET, 64'h0101_0101_0101_0101, 64'd0, 0);
      wait_idle();

      // refuse all inserts, then tiny limit
      write_load(7'd0);
      send_item(oaht_pkg::CMD_SET, 64'h42, 64'd7, 0);
      send_item(oaht_pkg::CMD_SET, 64'h41, 64'd9, 0);
      wait_idle();
      write_load(7'd1);
      random_phase(60, 30);

      write_load(7'd70);
      random_phase(500, 40);
      write_load(7'd100);
      random_phase(500, 20);
      // above 100: the load limit allows more inserts than the table has slots
      write_load(7'd127);
      random_phase(500, 10);
      write_load(7'd50);
      random_phase(100, 60);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #200ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_if.sv
hdl/oaht_front.sv
hdl/oaht_queue.sv
hdl/oaht_back.sv
hdl/open_addressing_hash_table.sv
bench/open_addressing_hash_table_checker.sv
bench/open_addressing_hash_table_tb.sv
